// ===== rtl/abrp_pkg.sv =====
// Shared constants and types for the aged buffer reuse pool.
package abrp_pkg;
  localparam int POOL_ENTRIES = 64;
  localparam int SIZE_BITS    = 40;
  localparam int HANDLE_BITS  = 16;
  localparam int FRAME_BITS   = 32;
  localparam int AGE_BITS     = 8;
  localparam logic [AGE_BITS-1:0] MAX_AGE_RST = 8'd6;

  localparam logic [1:0] OP_RELEASE = 2'd0;
  localparam logic [1:0] OP_REQUEST = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_MISS    = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_INVALID = 2'd3;

  localparam logic [1:0] MEM_ANY = 2'd0;

  typedef enum logic [1:0] {
    FSM_IDLE = 2'b01,
    FSM_SCAN = 2'b10
  } fsm_t;
endpackage

// ===== rtl/abrp_if.sv =====
// Valid/ready channel interfaces for the pool's input and result words.
interface abrp_in_if #(
  parameter int SIZE_BITS   = abrp_pkg::SIZE_BITS,
  parameter int HANDLE_BITS = abrp_pkg::HANDLE_BITS
);
  logic                   valid;
  logic                   ready;
  logic [1:0]             opcode;
  logic [SIZE_BITS-1:0]   buf_bytes;
  logic [7:0]             usage_bits;
  logic [1:0]             memory_kind;
  logic                   exact_size;
  logic [HANDLE_BITS-1:0] handle_in;
  modport source (output valid, opcode, buf_bytes, usage_bits, memory_kind, exact_size,
                  handle_in, input ready);
  modport sink (input valid, opcode, buf_bytes, usage_bits, memory_kind, exact_size,
                handle_in, output ready);
endinterface

interface abrp_out_if #(
  parameter int SIZE_BITS   = abrp_pkg::SIZE_BITS,
  parameter int HANDLE_BITS = abrp_pkg::HANDLE_BITS
);
  logic                           valid;
  logic                           ready;
  logic [1:0]                     status;
  logic [HANDLE_BITS-1:0]         handle_out;
  logic [SIZE_BITS-1:0]           granted_size;
  logic [SIZE_BITS-1:0]           exposed_size;
  logic [abrp_pkg::FRAME_BITS-1:0] frame_count;
  modport source (output valid, status, handle_out, granted_size, exposed_size,
                  frame_count, input ready);
  modport sink (input valid, status, handle_out, granted_size, exposed_size,
                frame_count, output ready);
endinterface

// ===== rtl/aged_buffer_reuse_pool.sv =====
// Top level of the aged buffer reuse pool: entry memory, scan and compaction control.
// Release, no-op and invalid-usage words: result valid in the cycle after the word is taken.
// Request and tick sweep the pool through the registered-read entry memory,
// compacting in place, and raise the result when the sweep ends.
// One word in work at a time: a new word is taken only when the pool is idle
// and the previous result has been taken.
// Synchronous active-low reset empties the pool, clears the frame counter, max_age = 6.
module aged_buffer_reuse_pool #(
  parameter int POOL_ENTRIES = abrp_pkg::POOL_ENTRIES,
  parameter int SIZE_BITS    = abrp_pkg::SIZE_BITS,
  parameter int HANDLE_BITS  = abrp_pkg::HANDLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [abrp_pkg::AGE_BITS-1:0] cfg_wdata,
  abrp_in_if.sink                       in_ch,
  abrp_out_if.source                    out_ch
);
  localparam int AW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int CW = $clog2(POOL_ENTRIES + 1);
  localparam int FB = abrp_pkg::FRAME_BITS;
  localparam int EW = HANDLE_BITS + SIZE_BITS + 8 + 2 + FB;
  localparam logic [CW-1:0] FULL_CNT = CW'(POOL_ENTRIES);

  logic [EW-1:0] mem_q [POOL_ENTRIES];
  logic [EW-1:0] rdata_r;
  logic          we;
  logic [AW-1:0] waddr;
  logic [EW-1:0] wdata;
  logic [AW-1:0] raddr;

  abrp_pkg::fsm_t st_r, st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, rd_r, rd_nxt, wr_r, wr_nxt;
  logic          pend_r, pend_nxt, found_r, found_nxt;
  logic [FB-1:0] frame_r, frame_nxt;
  logic [abrp_pkg::AGE_BITS-1:0] age_r, age_nxt;
  logic [1:0]    op_r, op_nxt, kind_r, kind_nxt;
  logic [SIZE_BITS-1:0] size_r, size_nxt;
  logic [7:0]    usage_r, usage_nxt;
  logic          exact_r, exact_nxt;
  logic          ov_r, ov_nxt;
  logic [1:0]    os_r, os_nxt;
  logic [HANDLE_BITS-1:0] oh_r, oh_nxt;
  logic [SIZE_BITS-1:0]   og_r, og_nxt, oe_r, oe_nxt;
  logic [FB-1:0] of_r, of_nxt;

  logic [HANDLE_BITS-1:0] e_handle;
  logic [SIZE_BITS-1:0]   e_size, diff;
  logic [7:0]             e_usage;
  logic [1:0]             e_kind;
  logic [FB-1:0]          e_stamp;
  logic size_ok, match, aged, drop, acc;

  assign {e_handle, e_size, e_usage, e_kind, e_stamp} = rdata_r;
  assign diff    = e_size - size_r;
  assign size_ok = (e_size == size_r) || (!exact_r && e_size >= size_r && diff <= size_r);
  assign match   = size_ok && e_usage == usage_r && (e_kind == kind_r || kind_r == abrp_pkg::MEM_ANY);
  assign aged    = ({1'b0, e_stamp} + {{(FB + 1 - abrp_pkg::AGE_BITS){1'b0}}, age_r})
                   < {1'b0, frame_r};
  assign drop    = (op_r == abrp_pkg::OP_TICK) ? aged : (!found_r && match);

  assign in_ch.ready         = (st_r == abrp_pkg::FSM_IDLE) && !ov_r;
  assign acc                 = in_ch.valid && in_ch.ready;
  assign out_ch.valid        = ov_r;
  assign out_ch.status       = os_r;
  assign out_ch.handle_out   = oh_r;
  assign out_ch.granted_size = og_r;
  assign out_ch.exposed_size = oe_r;
  assign out_ch.frame_count  = of_r;

  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; rd_nxt = rd_r; wr_nxt = wr_r;
    pend_nxt = 1'b0; found_nxt = found_r; frame_nxt = frame_r;
    age_nxt = cfg_we ? cfg_wdata : age_r;
    op_nxt = op_r; kind_nxt = kind_r; size_nxt = size_r; usage_nxt = usage_r;
    exact_nxt = exact_r;
    ov_nxt = ov_r && !out_ch.ready;
    os_nxt = os_r; oh_nxt = oh_r; og_nxt = og_r; oe_nxt = oe_r; of_nxt = of_r;
    we = 1'b0; waddr = wr_r[AW-1:0]; raddr = rd_r[AW-1:0];
    wdata = rdata_r;
    case (st_r)
      abrp_pkg::FSM_IDLE: begin
        if (acc) begin
          op_nxt = in_ch.opcode; kind_nxt = in_ch.memory_kind; size_nxt = in_ch.buf_bytes;
          usage_nxt = in_ch.usage_bits; exact_nxt = in_ch.exact_size;
          os_nxt = abrp_pkg::ST_DONE; oh_nxt = '0; og_nxt = '0; oe_nxt = '0;
          of_nxt = frame_r;
          rd_nxt = '0; wr_nxt = '0; found_nxt = 1'b0;
          case (in_ch.opcode)
            abrp_pkg::OP_RELEASE: begin
              ov_nxt = 1'b1;
              if (in_ch.usage_bits == 8'd0) begin
                os_nxt = abrp_pkg::ST_INVALID;
              end else if (cnt_r >= FULL_CNT) begin
                os_nxt = abrp_pkg::ST_FULL;
              end else begin
                we = 1'b1; waddr = cnt_r[AW-1:0];
                wdata = {in_ch.handle_in, in_ch.buf_bytes, in_ch.usage_bits,
                         in_ch.memory_kind, frame_r};
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            abrp_pkg::OP_REQUEST: begin
              if (in_ch.usage_bits == 8'd0) begin
                os_nxt = abrp_pkg::ST_INVALID; ov_nxt = 1'b1;
              end else begin
                st_nxt = abrp_pkg::FSM_SCAN;
              end
            end
            abrp_pkg::OP_TICK: st_nxt = abrp_pkg::FSM_SCAN;
            default: ov_nxt = 1'b1;
          endcase
        end
      end
      abrp_pkg::FSM_SCAN: begin
        if (rd_r < cnt_r) begin
          rd_nxt = rd_r + 1'b1; pend_nxt = 1'b1;
        end
        if (pend_r) begin
          if (drop) begin
            if (op_r == abrp_pkg::OP_REQUEST) begin
              found_nxt = 1'b1; oh_nxt = e_handle; og_nxt = e_size; oe_nxt = size_r;
            end
          end else begin
            we = 1'b1; wr_nxt = wr_r + 1'b1;
          end
        end else if (rd_r >= cnt_r) begin
          st_nxt = abrp_pkg::FSM_IDLE; cnt_nxt = wr_r; ov_nxt = 1'b1;
          if (op_r == abrp_pkg::OP_TICK) begin
            frame_nxt = frame_r + 1'b1; of_nxt = frame_r + 1'b1;
            os_nxt = abrp_pkg::ST_DONE;
          end else begin
            os_nxt = found_r ? abrp_pkg::ST_DONE : abrp_pkg::ST_MISS;
          end
        end
      end
      default: st_nxt = abrp_pkg::FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_r <= mem_q[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= abrp_pkg::FSM_IDLE; cnt_r <= '0; rd_r <= '0; wr_r <= '0;
      pend_r <= 1'b0; found_r <= 1'b0; frame_r <= '0;
      age_r <= abrp_pkg::MAX_AGE_RST; ov_r <= 1'b0; op_r <= abrp_pkg::OP_RELEASE;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; rd_r <= rd_nxt; wr_r <= wr_nxt;
      pend_r <= pend_nxt; found_r <= found_nxt; frame_r <= frame_nxt;
      age_r <= age_nxt; ov_r <= ov_nxt; op_r <= op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt; size_r <= size_nxt; usage_r <= usage_nxt; exact_r <= exact_nxt;
    os_r <= os_nxt; oh_r <= oh_nxt; og_r <= og_nxt; oe_r <= oe_nxt; of_r <= of_nxt;
  end
endmodule
